### src/rational_arith_unit_top_macros.svh
// Assertion helpers used by rau_ctrl. Clock is clk, reset is rst.
`ifndef RATIONAL_ARITH_UNIT_TOP_MACROS_SVH
`define RATIONAL_ARITH_UNIT_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RAU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/rau_pkg.sv
package rau_pkg;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_SUB = 2'd1;
  localparam logic [1:0] KIND_MUL = 2'd2;
  localparam logic [1:0] KIND_DIV = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  localparam int OPD_W = 32;
  localparam int NUM_W = 64;
  localparam int DEN_W = 63;

  typedef enum logic [3:0] {
    DP_NONE, DP_LOAD, DP_MUL0, DP_MUL1, DP_MUL2, DP_COMB, DP_GINIT,
    DP_GSH, DP_GX, DP_GY, DP_DIVN, DP_CAPN, DP_DIVD, DP_CAPD, DP_OUT
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_COMB, S_CHK, S_GSH, S_GX, S_GY,
    S_DIVN, S_WAITN, S_DIVD, S_WAITD, S_OUT
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_zero;
    logic rn_zero;
    logic both_even;
    logic x_even;
    logic y_zero;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

### src/rational_arith_unit_top.sv
// Sequence: load, three multiplies on the shared multiplier and combine, then binary GCD
//   steps and two restoring divides on the single shared divider; zero and divide-by-zero
//   cases skip the GCD and the divides. A new item is accepted only once the previous
//   result has been written to the output register.
// Reset: rst, synchronous active high, clears the controller and output valid; no
//   storage needs a clearing pass.
module rational_arith_unit_top #(
  parameter int WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  // input beat
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,  // a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
  input  logic [1:0]   s_tuser,  // kind[1:0]
  // result beat
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata   // res_num[63:0], res_den[126:64], status[128:127], zero pad
);

  // Operands are sign-split into magnitudes; results carry the sign on the numerator.
  // A finished result sits in the output register while the next beat may be accepted.

  rau_pkg::dp_cmd_t    cmd;
  rau_pkg::dp_status_t st;

  logic [rau_pkg::NUM_W-1:0] res_num;
  logic [rau_pkg::DEN_W-1:0] res_den;
  logic [1:0]                status;

  rau_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  rau_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .kind_in   (s_tuser),
    .a_num     (s_tdata[31:0]),
    .a_den     (s_tdata[63:32]),
    .b_num     (s_tdata[95:64]),
    .b_den     (s_tdata[127:96]),
    .res_num   (res_num),
    .res_den   (res_den),
    .status    (status),
    .out_valid (m_tvalid),
    .out_ready (m_tready)
  );

  assign m_tdata = {7'b0, status, res_den, res_num};

endmodule

### src/rau_div.sv
module rau_div #(
  parameter int DW = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] quo;
  logic [DW-1:0] dsr;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem, quo[DW-1]};
  assign fits  = trial >= {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // one quotient bit a cycle, restoring
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= DW'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[DW-1:0];
      end
      quo <= {quo[DW-2:0], fits};
    end
  end

endmodule

### src/rau_datapath.sv
module rau_datapath #(
  parameter int WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  rau_pkg::dp_cmd_t            cmd,
  output rau_pkg::dp_status_t         st,
  input  logic [1:0]                  kind_in,
  input  logic [rau_pkg::OPD_W-1:0]   a_num,
  input  logic [rau_pkg::OPD_W-1:0]   a_den,
  input  logic [rau_pkg::OPD_W-1:0]   b_num,
  input  logic [rau_pkg::OPD_W-1:0]   b_den,
  output logic [rau_pkg::NUM_W-1:0]   res_num,
  output logic [rau_pkg::DEN_W-1:0]   res_den,
  output logic [1:0]                  status,
  output logic                        out_valid,
  input  logic                        out_ready
);

  localparam int W  = WIDTH;
  localparam int PW = 2 * WIDTH;

  logic [1:0]    kind;
  logic [W-1:0]  an, ad, bn, bd;
  logic          a_neg, b_neg, div_zero;
  logic [PW-1:0] p, q, rd, rn;
  logic          r_neg;
  logic [PW-1:0] x, y, rns, rds, rnq, rdq;

  logic [W-1:0]  an_m, ad_m, bn_m, bd_m;
  logic          an_s, ad_s, bn_s, bd_s;
  logic [W-1:0]  opa, opb;
  logic [PW-1:0] prod;
  logic          q_neg;
  logic          div_start, div_done;
  logic [PW-1:0] div_dend, div_quo;
  logic [rau_pkg::NUM_W-1:0] rn64, rd64;

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
    return v[W-1] ? W'(-v) : v;
  endfunction

  always_comb begin
    an_s = a_num[W-1];
    ad_s = a_den[W-1];
    bn_s = b_num[W-1];
    bd_s = b_den[W-1];
    an_m = mag_of(a_num[W-1:0]);
    ad_m = mag_of(a_den[W-1:0]);
    bn_m = mag_of(b_num[W-1:0]);
    bd_m = mag_of(b_den[W-1:0]);
    // zero denominator reads as +1
    if (ad_m == '0) begin
      ad_m = W'(1);
      ad_s = 1'b0;
    end
    if (bd_m == '0) begin
      bd_m = W'(1);
      bd_s = 1'b0;
    end
  end

  // shared multiplier
  always_comb begin
    opa = an;
    opb = bd;
    unique case (cmd.op)
      rau_pkg::DP_MUL0: begin
        opa = an;
        opb = (kind == rau_pkg::KIND_MUL) ? bn : bd;
      end
      rau_pkg::DP_MUL1: begin
        opa = bn;
        opb = ad;
      end
      rau_pkg::DP_MUL2: begin
        opa = ad;
        opb = (kind == rau_pkg::KIND_DIV) ? bn : bd;
      end
      default: begin
        opa = an;
        opb = bd;
      end
    endcase
  end

  assign prod  = {{W{1'b0}}, opa} * {{W{1'b0}}, opb};
  assign q_neg = (kind == rau_pkg::KIND_SUB) ? !b_neg : b_neg;

  assign div_start = (cmd.op == rau_pkg::DP_DIVN) || (cmd.op == rau_pkg::DP_DIVD);
  assign div_dend  = (cmd.op == rau_pkg::DP_DIVD) ? rds : rns;

  rau_div #(.DW(PW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dend),
    .divisor  (x),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      rau_pkg::DP_LOAD: begin
        kind     <= kind_in;
        an       <= an_m;
        ad       <= ad_m;
        bn       <= bn_m;
        bd       <= bd_m;
        a_neg    <= an_s != ad_s;
        b_neg    <= bn_s != bd_s;
        div_zero <= (kind_in == rau_pkg::KIND_DIV) && (bn_m == '0);
      end
      rau_pkg::DP_MUL0: p  <= prod;
      rau_pkg::DP_MUL1: q  <= prod;
      rau_pkg::DP_MUL2: rd <= prod;
      rau_pkg::DP_COMB: begin
        if (kind == rau_pkg::KIND_ADD || kind == rau_pkg::KIND_SUB) begin
          if (a_neg == q_neg) begin
            rn    <= p + q;
            r_neg <= a_neg;
          end else if (p >= q) begin
            rn    <= p - q;
            r_neg <= a_neg;
          end else begin
            rn    <= q - p;
            r_neg <= q_neg;
          end
        end else begin
          rn    <= p;
          r_neg <= a_neg != b_neg;
        end
      end
      rau_pkg::DP_GINIT: begin
        x   <= rn;
        y   <= rd;
        rns <= rn;
        rds <= rd;
      end
      // common power of two comes out of the operands directly
      rau_pkg::DP_GSH: begin
        x   <= x >> 1;
        y   <= y >> 1;
        rns <= rns >> 1;
        rds <= rds >> 1;
      end
      rau_pkg::DP_GX: x <= x >> 1;
      rau_pkg::DP_GY: begin
        if (!y[0]) begin
          y <= y >> 1;
        end else if (x > y) begin
          x <= y;
          y <= x - y;
        end else begin
          y <= y - x;
        end
      end
      rau_pkg::DP_CAPN: rnq <= div_quo;
      rau_pkg::DP_CAPD: rdq <= div_quo;
      default: begin
      end
    endcase
  end

  assign rn64 = rau_pkg::NUM_W'(rnq);
  assign rd64 = rau_pkg::NUM_W'(rdq);

  always_ff @(posedge clk) begin
    if (cmd.op == rau_pkg::DP_OUT) begin
      if (div_zero) begin
        res_num <= '0;
        res_den <= rau_pkg::DEN_W'(1);
        status  <= rau_pkg::ST_DIV0;
      end else if (rn == '0) begin
        res_num <= '0;
        res_den <= rau_pkg::DEN_W'(1);
        status  <= rau_pkg::ST_OK;
      end else begin
        res_den <= rd64[rau_pkg::DEN_W-1:0];
        if (!r_neg && rn64[rau_pkg::NUM_W-1]) begin
          res_num <= {1'b0, {(rau_pkg::NUM_W-1){1'b1}}};
          status  <= rau_pkg::ST_OVF;
        end else begin
          res_num <= r_neg ? rau_pkg::NUM_W'(-rn64) : rn64;
          status  <= rau_pkg::ST_OK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == rau_pkg::DP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    st.div_zero  = div_zero;
    st.rn_zero   = (rn == '0);
    st.both_even = !x[0] && !y[0];
    st.x_even    = !x[0];
    st.y_zero    = (y == '0);
    st.div_done  = div_done;
    st.out_free  = !out_valid || out_ready;
  end

endmodule

### src/rau_ctrl.sv
`include "rational_arith_unit_top_macros.svh"

module rau_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rau_pkg::dp_status_t st,
  output rau_pkg::dp_cmd_t    cmd
);

  rau_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rau_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = rau_pkg::DP_NONE;
    in_ready   = (state == rau_pkg::S_IDLE);
    unique case (state)
      rau_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.op     = rau_pkg::DP_LOAD;
          state_next = rau_pkg::S_MUL0;
        end
      end
      rau_pkg::S_MUL0: begin
        cmd.op     = rau_pkg::DP_MUL0;
        state_next = rau_pkg::S_MUL1;
      end
      rau_pkg::S_MUL1: begin
        cmd.op     = rau_pkg::DP_MUL1;
        state_next = rau_pkg::S_MUL2;
      end
      rau_pkg::S_MUL2: begin
        cmd.op     = rau_pkg::DP_MUL2;
        state_next = rau_pkg::S_COMB;
      end
      rau_pkg::S_COMB: begin
        cmd.op     = rau_pkg::DP_COMB;
        state_next = rau_pkg::S_CHK;
      end
      rau_pkg::S_CHK: begin
        if (st.div_zero || st.rn_zero) begin
          state_next = rau_pkg::S_OUT;
        end else begin
          cmd.op     = rau_pkg::DP_GINIT;
          state_next = rau_pkg::S_GSH;
        end
      end
      rau_pkg::S_GSH: begin
        if (st.both_even) begin
          cmd.op = rau_pkg::DP_GSH;
        end else begin
          state_next = rau_pkg::S_GX;
        end
      end
      rau_pkg::S_GX: begin
        if (st.x_even) begin
          cmd.op = rau_pkg::DP_GX;
        end else begin
          state_next = rau_pkg::S_GY;
        end
      end
      rau_pkg::S_GY: begin
        if (st.y_zero) begin
          state_next = rau_pkg::S_DIVN;
        end else begin
          cmd.op = rau_pkg::DP_GY;
        end
      end
      rau_pkg::S_DIVN: begin
        cmd.op     = rau_pkg::DP_DIVN;
        state_next = rau_pkg::S_WAITN;
      end
      rau_pkg::S_WAITN: begin
        if (st.div_done) begin
          cmd.op     = rau_pkg::DP_CAPN;
          state_next = rau_pkg::S_DIVD;
        end
      end
      rau_pkg::S_DIVD: begin
        cmd.op     = rau_pkg::DP_DIVD;
        state_next = rau_pkg::S_WAITD;
      end
      rau_pkg::S_WAITD: begin
        if (st.div_done) begin
          cmd.op     = rau_pkg::DP_CAPD;
          state_next = rau_pkg::S_OUT;
        end
      end
      rau_pkg::S_OUT: begin
        if (st.out_free) begin
          cmd.op     = rau_pkg::DP_OUT;
          state_next = rau_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rau_pkg::S_IDLE;
      end
    endcase
  end

  `RAU_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state == rau_pkg::S_MUL0, "accept did not start multiply")
  `RAU_ASSERT_NEXT(a_special_skips_gcd, state == rau_pkg::S_CHK && (st.div_zero || st.rn_zero), state == rau_pkg::S_OUT, "special case entered gcd")
  `RAU_ASSERT_SAME(a_div_done_waiting, st.div_done, state == rau_pkg::S_WAITN || state == rau_pkg::S_WAITD, "divider done outside wait")
  `RAU_ASSERT_SAME(a_out_only_when_free, cmd.op == rau_pkg::DP_OUT, st.out_free, "result written over pending beat")

endmodule

### test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Expected fraction for one input beat
  typedef struct packed {
    logic [63:0] num;
    logic [62:0] den;
    logic [1:0]  status;
  } frac_res_t;

  // Scoreboard: predicts reduced fractions and checks result beats in order
  class frac_scoreboard;
    frac_res_t pending[$];
    int errors;
    int checked;

    function new();
      errors = 0;
      checked = 0;
    endfunction

    // Magnitude of a 32-bit operand; returns sign bit via neg
    function automatic logic [63:0] mag_of(logic [31:0] v, output bit neg);
      neg = v[31];
      return neg ? {32'd0, (~v) + 32'd1} : {32'd0, v};
    endfunction

    function automatic logic [63:0] bin_gcd(logic [63:0] x, logic [63:0] y);
      int sh;
      logic [63:0] t;
      sh = 0;
      if (x == 0) return y;
      if (y == 0) return x;
      while (((x | y) & 64'd1) == 0) begin
        x = x >> 1;
        y = y >> 1;
        sh++;
      end
      while (x[0] == 1'b0) x = x >> 1;
      while (y != 0) begin
        while (y[0] == 1'b0) y = y >> 1;
        if (x > y) begin
          t = x;
          x = y;
          y = t;
        end
        y = y - x;
      end
      return x << sh;
    endfunction

    function automatic void note_input(logic [1:0] kind, logic [31:0] a_n, logic [31:0] a_d,
                                       logic [31:0] b_n, logic [31:0] b_d);
      bit an_neg, ad_neg, bn_neg, bd_neg, a_neg, b_neg, q_neg, r_neg;
      logic [63:0] an, ad, bn, bd, p, q, rn, rd, g;
      frac_res_t r;
      an = mag_of(a_n, an_neg);
      ad = mag_of(a_d, ad_neg);
      bn = mag_of(b_n, bn_neg);
      bd = mag_of(b_d, bd_neg);
      if (ad == 0) begin
        ad = 1;
        ad_neg = 0;
      end
      if (bd == 0) begin
        bd = 1;
        bd_neg = 0;
      end
      a_neg = an_neg ^ ad_neg;
      b_neg = bn_neg ^ bd_neg;
      r.num = 0;
      r.den = 1;
      r.status = rau_pkg::ST_OK;
      if (kind == rau_pkg::KIND_DIV && bn == 0) begin
        r.status = rau_pkg::ST_DIV0;
        pending.push_back(r);
        return;
      end
      case (kind)
        rau_pkg::KIND_ADD, rau_pkg::KIND_SUB: begin
          p = an * bd;
          q = bn * ad;
          q_neg = (kind == rau_pkg::KIND_SUB) ? !b_neg : b_neg;
          rd = ad * bd;
          if (a_neg == q_neg) begin
            rn = p + q;
            r_neg = a_neg;
          end else if (p >= q) begin
            rn = p - q;
            r_neg = a_neg;
          end else begin
            rn = q - p;
            r_neg = q_neg;
          end
        end
        rau_pkg::KIND_MUL: begin
          rn = an * bn;
          rd = ad * bd;
          r_neg = a_neg ^ b_neg;
        end
        default: begin
          rn = an * bd;
          rd = ad * bn;
          r_neg = a_neg ^ b_neg;
        end
      endcase
      if (rn != 0) begin
        g = bin_gcd(rn, rd);
        rn = rn / g;
        rd = rd / g;
        // positive magnitude past 2^63-1 clamps
        if (!r_neg && rn[63]) begin
          rn = 64'h7fff_ffff_ffff_ffff;
          r.status = rau_pkg::ST_OVF;
        end
        r.num = r_neg ? (64'd0 - rn) : rn;
        r.den = rd[62:0];
      end
      pending.push_back(r);
    endfunction

    function automatic void check_result(logic [135:0] d);
      frac_res_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[63:0] !== e.num) begin
        $error("res_num expected %h actual %h", e.num, d[63:0]);
        errors++;
      end
      if (d[126:64] !== e.den) begin
        $error("res_den expected %h actual %h", e.den, d[126:64]);
        errors++;
      end
      if (d[128:127] !== e.status) begin
        $error("status expected %0d actual %0d", e.status, d[128:127]);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;   // a_num, a_den, b_num, b_den from bit 0 up
  logic [1:0]   s_tuser;   // kind
  logic         m_tvalid;
  logic         m_tready;
  logic [135:0] m_tdata;   // res_num, res_den, status, pad from bit 0 up

  frac_scoreboard sb;
  int   sent;
  longint cycles;

  rational_arith_unit_top #(.WIDTH(32)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: counts clock cycles and fails the run once the count passes its limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 2_000_000) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Send one fraction pair after a random gap, hold until accepted.
  // Valid stays up after the accept; the next call or the caller drops it.
  task automatic send_pair(logic [1:0] kind, logic [31:0] a_n, logic [31:0] a_d,
                           logic [31:0] b_n, logic [31:0] b_d);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b_d, b_n, a_d, a_num_fix(a_n)};
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
    sb.note_input(kind, a_n, a_d, b_n, b_d);
    sent++;
  endtask

  function automatic logic [31:0] a_num_fix(logic [31:0] v);
    return v;
  endfunction

  // Random operand: mix of edge values, small values and full-range values
  function automatic logic [31:0] rand_opd();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3, 4: return $urandom_range(0, 40) - 20;
      5: return $urandom_range(0, 4000) - 2000;
      default: return $urandom;
    endcase
  endfunction

  // Result side: random stalls, with runs of always-ready
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_result(m_tdata);
    end
  end

  initial begin
    sb = new();
    sent = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = rau_pkg::KIND_ADD;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every operation, zero denominators, zero numerators,
    // divide by a zero fraction, negative denominators, and the most
    // negative and the largest positive operands.
    send_pair(rau_pkg::KIND_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_pair(rau_pkg::KIND_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
    send_pair(rau_pkg::KIND_SUB, 32'd1, 32'd3, 32'd1, 32'd2);
    send_pair(rau_pkg::KIND_MUL, -32'sd4, 32'd6, 32'd3, -32'sd8);
    send_pair(rau_pkg::KIND_DIV, 32'd5, 32'd7, 32'd0, 32'd3);
    send_pair(rau_pkg::KIND_DIV, 32'd0, 32'd7, 32'd0, 32'd0);
    send_pair(rau_pkg::KIND_ADD, 32'd5, 32'd0, 32'd7, 32'd0);
    send_pair(rau_pkg::KIND_MUL, 32'd0, 32'd9, 32'd5, 32'd3);
    send_pair(rau_pkg::KIND_MUL, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
    send_pair(rau_pkg::KIND_DIV, 32'h8000_0000, 32'd1, 32'd1, 32'h8000_0000);
    send_pair(rau_pkg::KIND_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h8000_0000);
    send_pair(rau_pkg::KIND_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              32'h8000_0000);
    send_pair(rau_pkg::KIND_SUB, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'd1);
    send_pair(rau_pkg::KIND_MUL, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
              32'hffff_ffff);
    send_pair(rau_pkg::KIND_DIV, 32'd6, -32'sd4, -32'sd9, 32'd12);
    send_pair(rau_pkg::KIND_ADD, 32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa,
              32'h5555_5555);
    s_tvalid <= 1'b0;

    // Hold the sender until the block has drained
    while (sb.pending.size() != 0) @(posedge clk);

    // Random part
    repeat (1000) begin
      send_pair(2'($urandom_range(0, 3)), rand_opd(), rand_opd(), rand_opd(), rand_opd());
    end
    s_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);

    $display("Sent %0d fraction pairs over all four operations, checked %0d results.",
             sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
